// ===== sv/running_min_max_mean_variance_macros.svh =====
// Assertion macros for the running statistics block.
`ifndef RUNNING_MIN_MAX_MEAN_VARIANCE_MACROS_SVH
`define RUNNING_MIN_MAX_MEAN_VARIANCE_MACROS_SVH

`ifndef SYNTHESIS
// Plain property, clocked on clk, off during reset
`define RMMV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("rmmv assertion failed");
// Same-cycle implication
`define RMMV_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmmv implication failed");
`else
`define RMMV_ASSERT(lbl, prop)
`define RMMV_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ===== sv/rmmv_pkg.sv =====
// Shared widths, constants and types of the running statistics block.
`timescale 1ns / 1ps
package rmmv_pkg;

	localparam int SAMPLE_W = 32;
	localparam int FRAC_W   = 16;
	localparam int CNT_W    = 16;
	localparam int MEAN_W   = SAMPLE_W + FRAC_W;   // Q32.16 running mean
	localparam int DELTA_W  = MEAN_W + 1;
	localparam int SUM_W    = 64;
	localparam int PROD_W   = 2 * SAMPLE_W;
	localparam int DIV_W    = 64;
	localparam int PAD_W    = DIV_W - 1 - MEAN_W;
	localparam int STEP_W   = 7;

	localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(DIV_W - PAD_W);
	localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(DIV_W);

	localparam logic [CNT_W-1:0]    MAX_ITEMS      = CNT_W'(65535);
	localparam logic [SAMPLE_W-1:0] SMALLEST_RESET = 32'h7FFF_FFFF;
	localparam logic [SAMPLE_W-1:0] VAR_SAT        = '1;

	// divider request and status
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== sv/rmmv_if.sv =====
// Valid/ready channel interfaces for sample input and result output.
`timescale 1ns / 1ps
interface rmmv_in_if import rmmv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       last;

	modport source (output valid, output sample, output last, input ready);
	modport sink (input valid, input sample, input last, output ready);
endinterface

interface rmmv_out_if import rmmv_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] max_value;
	logic signed [SAMPLE_W-1:0] min_value;
	logic signed [SAMPLE_W-1:0] mean_value;
	logic [SAMPLE_W-1:0]        variance_value;
	logic [CNT_W-1:0]           item_count;

	modport source (output valid, output max_value, output min_value, output mean_value,
		output variance_value, output item_count, input ready);
	modport sink (input valid, input max_value, input min_value, input mean_value,
		input variance_value, input item_count, output ready);
endinterface

// ===== sv/running_min_max_mean_variance.sv =====
// Each accepted word passes DELTA, DSTART, DIVM (mean division), UPD, AFTER, MUL and ACC.
// A last word adds a variance division (VSTART, DIVV) and then EMIT, which loads the result register.
// A new word is accepted only back in IDLE; EMIT waits while an older result is still held.
// The result register frees the input side while a result waits to be taken.
// Reset (arst_n low, asynchronous): count, mean, sum cleared, max 0, min 0x7FFFFFFF.
`timescale 1ns / 1ps
`include "running_min_max_mean_variance_macros.svh"
module running_min_max_mean_variance import rmmv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	rmmv_in_if.sink    samples,
	rmmv_out_if.source results
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DELTA  = 11'b000_0000_0010,
		ST_DSTART = 11'b000_0000_0100,
		ST_DIVM   = 11'b000_0000_1000,
		ST_UPD    = 11'b000_0001_0000,
		ST_AFTER  = 11'b000_0010_0000,
		ST_MUL    = 11'b000_0100_0000,
		ST_ACC    = 11'b000_1000_0000,
		ST_VSTART = 11'b001_0000_0000,
		ST_DIVV   = 11'b010_0000_0000,
		ST_EMIT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;

	logic [CNT_W-1:0]           seen_count_q;
	logic signed [SAMPLE_W-1:0] largest_q;
	logic signed [SAMPLE_W-1:0] smallest_q;
	logic [MEAN_W-1:0]          mean_q;
	logic [SUM_W-1:0]           dev_sum_q;
	logic                       res_valid_q;

	logic [SAMPLE_W-1:0]   sample_q;
	logic                  last_q;
	logic [DELTA_W-1:0]    delta_q;
	logic [SAMPLE_W-1:0]   a_q;
	logic [SAMPLE_W-1:0]   b_q;
	logic [PROD_W-1:0]     prod_q;

	logic signed [SAMPLE_W-1:0] max_q;
	logic signed [SAMPLE_W-1:0] min_q;
	logic signed [SAMPLE_W-1:0] mean_out_q;
	logic [SAMPLE_W-1:0]        var_q;
	logic [CNT_W-1:0]           cnt_out_q;

	div_ctl_t         div_ctl;
	div_sts_t         div_sts;
	logic [DIV_W-1:0] div_dividend;
	logic [DIV_W-1:0] div_quot;

	logic                 in_acc;
	logic                 emit_ok;
	logic [MEAN_W-1:0]    x;
	logic [DELTA_W-1:0]   delta_mag;
	logic [DELTA_W-1:0]   after;
	logic [DELTA_W-1:0]   after_mag;
	logic [MEAN_W-1:0]    quot_m;
	logic [SUM_W:0]       sum_ext;
	logic [SAMPLE_W-1:0]  var_sat;

	assign samples.ready = (state_q == ST_IDLE);
	assign in_acc        = samples.valid && samples.ready;
	assign emit_ok       = !res_valid_q || results.ready;

	// datapath helpers
	always_comb begin
		x         = {sample_q, {FRAC_W{1'b0}}};
		delta_mag = delta_q[DELTA_W-1] ? (~delta_q + DELTA_W'(1)) : delta_q;
		after     = {x[MEAN_W-1], x} - {mean_q[MEAN_W-1], mean_q};
		after_mag = after[DELTA_W-1] ? (~after + DELTA_W'(1)) : after;
		quot_m    = div_quot[MEAN_W-1:0];
		sum_ext   = {1'b0, dev_sum_q} + {{(SUM_W + 1 - (PROD_W - FRAC_W)){1'b0}},
			prod_q[PROD_W-1:FRAC_W]};
		var_sat   = (div_quot[DIV_W-1:SAMPLE_W] != '0) ? VAR_SAT : div_quot[SAMPLE_W-1:0];
	end

	// divider request
	always_comb begin
		div_ctl.start = (state_q == ST_DSTART) || (state_q == ST_VSTART);
		div_ctl.steps = (state_q == ST_VSTART) ? VAR_STEPS : MEAN_STEPS;
		div_dividend  = (state_q == ST_VSTART) ? dev_sum_q
			: {1'b0, delta_mag[MEAN_W-1:0], {PAD_W{1'b0}}};
	end

	rmmv_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dividend),
		.divisor  (seen_count_q),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_DELTA;
			ST_DELTA:  state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DIVM;
			ST_DIVM:   if (div_sts.done) state_d = ST_UPD;
			ST_UPD:    state_d = ST_AFTER;
			ST_AFTER:  state_d = ST_MUL;
			ST_MUL:    state_d = ST_ACC;
			ST_ACC:    state_d = last_q ? ST_VSTART : ST_IDLE;
			ST_VSTART: state_d = ST_DIVV;
			ST_DIVV:   if (div_sts.done) state_d = ST_EMIT;
			ST_EMIT:   if (emit_ok) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// statistics state, cleared by reset and after each emitted result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			seen_count_q <= '0;
			largest_q    <= '0;
			smallest_q   <= SMALLEST_RESET;
			mean_q       <= '0;
			dev_sum_q    <= '0;
			res_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				if (seen_count_q != MAX_ITEMS) begin
					seen_count_q <= seen_count_q + CNT_W'(1);
				end
				if (samples.sample < smallest_q) begin
					smallest_q <= samples.sample;
				end
				if (samples.sample > largest_q) begin
					largest_q <= samples.sample;
				end
			end
			if (state_q == ST_UPD) begin
				mean_q <= delta_q[DELTA_W-1] ? (mean_q - quot_m) : (mean_q + quot_m);
			end
			if (state_q == ST_ACC) begin
				dev_sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			end
			if ((state_q == ST_EMIT) && emit_ok) begin
				res_valid_q  <= 1'b1;
				seen_count_q <= '0;
				largest_q    <= '0;
				smallest_q   <= SMALLEST_RESET;
				mean_q       <= '0;
				dev_sum_q    <= '0;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			sample_q <= samples.sample;
			last_q   <= samples.last;
		end
		if (state_q == ST_DELTA) begin
			delta_q <= {x[MEAN_W-1], x} - {mean_q[MEAN_W-1], mean_q};
		end
		if (state_q == ST_DSTART) begin
			a_q <= delta_mag[MEAN_W-1:FRAC_W];
		end
		if (state_q == ST_AFTER) begin
			b_q <= after_mag[MEAN_W-1:FRAC_W];
		end
		if (state_q == ST_MUL) begin
			prod_q <= a_q * b_q;
		end
		if ((state_q == ST_EMIT) && emit_ok) begin
			max_q      <= largest_q;
			min_q      <= smallest_q;
			mean_out_q <= mean_q[MEAN_W-1:FRAC_W];
			var_q      <= var_sat;
			cnt_out_q  <= seen_count_q;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.max_value      = max_q;
	assign results.min_value      = min_q;
	assign results.mean_value     = mean_out_q;
	assign results.variance_value = var_q;
	assign results.item_count     = cnt_out_q;

	`RMMV_ASSERT_IMPL(a_div_free_at_start, state_q == ST_DSTART, !div_sts.busy)
	`RMMV_ASSERT_IMPL(a_var_only_on_last, state_q == ST_VSTART, last_q)
	`RMMV_ASSERT_IMPL(a_min_not_above_max, seen_count_q != '0, smallest_q <= largest_q)
	`RMMV_ASSERT_IMPL(a_emit_needs_count, state_q == ST_EMIT, seen_count_q != '0)

endmodule

// ===== sv/rmmv_div.sv =====
// Shared radix-2 restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
`include "running_min_max_mean_variance_macros.svh"
module rmmv_div import rmmv_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DIV_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output div_sts_t         sts,
	output logic [DIV_W-1:0] quotient
);

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DIV_W-1:0]  acc_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;

	logic [CNT_W:0] rem_sh;
	logic [CNT_W:0] rem_sub;
	logic           fits;

	// one trial subtraction
	always_comb begin
		rem_sh  = {rem_q, acc_q[DIV_W-1]};
		rem_sub = rem_sh - {1'b0, dvs_q};
		fits    = (rem_sh >= {1'b0, dvs_q});
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == STEP_W'(1)) && !ctl.start;
			if (ctl.start) begin
				cnt_q <= ctl.steps;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - STEP_W'(1);
			end
		end
	end

	// dividend/quotient shift register and partial remainder
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			acc_q <= {acc_q[DIV_W-2:0], fits};
			rem_q <= fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign sts.busy = (cnt_q != '0);
	assign sts.done = done_q;
	assign quotient = acc_q;

	`RMMV_ASSERT_IMPL(a_div_no_restart, ctl.start, cnt_q == '0)
	`RMMV_ASSERT_IMPL(a_div_done_after_last, done_q, $past(cnt_q == STEP_W'(1)))
	`RMMV_ASSERT(a_div_cnt_range, cnt_q <= VAR_STEPS)

endmodule

// ===== tb/sv/running_min_max_mean_variance_tb.sv =====
// Self-checking testbench for the running min/max/mean/variance block.
`timescale 1ns / 1ps
module running_min_max_mean_variance_tb import rmmv_pkg::*; ();

	localparam int ITEM_TARGET    = 1450;
	localparam int IDLE_LIMIT     = 3000;  // cycles with no word moving on either side
	localparam int DRAIN_CYCLES   = 300;

	// one result word of the block
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] max_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SAMPLE_W-1:0] mean_value;
		logic [SAMPLE_W-1:0]        variance_value;
		logic [CNT_W-1:0]           item_count;
	} set_stats_t;

	typedef enum int {MIX_FULL, MIX_MODERATE, NEG_ONLY, NEAR_EXTREMES} set_flavor_t;

	// Running statistics predictor and queue of expected set results
	class stats_scoreboard;
		int unsigned                tally;
		longint                     mean_q32;
		logic [SUM_W-1:0]           dev_sum;
		logic signed [SAMPLE_W-1:0] top;
		logic signed [SAMPLE_W-1:0] bottom;
		set_stats_t                 expected_stats[$];
		int                         failures;
		int                         sets_checked;

		function void clear();
			tally = 0;
			mean_q32 = 0;
			dev_sum = '0;
			top = '0;
			bottom = SMALLEST_RESET;
		endfunction

		function new();
			failures = 0;
			sets_checked = 0;
			clear();
		endfunction

		// Welford update for one accepted sample word
		function void note_sample(logic signed [SAMPLE_W-1:0] s, logic fin);
			longint x, delta, after, n;
			logic [63:0] a, b, term, quot, mean_bits;
			logic [64:0] wide;
			set_stats_t exp_s;
			if (tally < MAX_ITEMS)
				tally++;
			if (s < bottom)
				bottom = s;
			if (s > top)
				top = s;
			x = longint'(s) * 65536;
			n = tally;
			delta = x - mean_q32;
			mean_q32 = mean_q32 + delta / n;  // truncates toward zero
			after = x - mean_q32;
			a = (delta < 0) ? -delta : delta;
			b = (after < 0) ? -after : after;
			a = a >> FRAC_W;
			b = b >> FRAC_W;
			term = (a * b) >> FRAC_W;
			wide = {1'b0, dev_sum} + {1'b0, term};
			dev_sum = wide[64] ? '1 : wide[63:0];
			if (!fin)
				return;
			quot = dev_sum / 64'(tally);
			mean_bits = mean_q32;
			exp_s.max_value = top;
			exp_s.min_value = bottom;
			exp_s.mean_value = mean_bits[47:16];  // floor of Q32.16
			exp_s.variance_value = (quot > 64'hFFFF_FFFF) ? VAR_SAT : quot[31:0];
			exp_s.item_count = (tally > 32'hFFFF) ? 16'hFFFF : 16'(tally);
			expected_stats.insert(expected_stats.size(), exp_s);
			clear();
		endfunction

		function void check_field(string field, longint want, longint got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", field, want, got);
				failures++;
			end
		endfunction

		function void check_result(set_stats_t got);
			set_stats_t want;
			if (expected_stats.size() == 0) begin
				$error("result word with no set pending: max %0d min %0d count %0d",
					got.max_value, got.min_value, got.item_count);
				failures++;
				return;
			end
			want = expected_stats.pop_front();
			sets_checked++;
			check_field("max_value", $signed(want.max_value), $signed(got.max_value));
			check_field("min_value", $signed(want.min_value), $signed(got.min_value));
			check_field("mean_value", $signed(want.mean_value), $signed(got.mean_value));
			check_field("variance_value", want.variance_value, got.variance_value);
			check_field("item_count", want.item_count, got.item_count);
		endfunction

		function int pending();
			return expected_stats.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rmmv_in_if  samples();
	rmmv_out_if results();

	running_min_max_mean_variance i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results)
	);

	stats_scoreboard book;
	bit              idle_on;
	int              words_sent;
	int              sets_sent;
	int              quiet_cycles = 0;
	int              stall_left = 0;

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Result side back-pressure: random stall bursts while idling is on
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			results.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(1, 10) - 1;
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
		end
	end

	// Result monitor
	always @(posedge clk) begin
		set_stats_t got;
		if (arst_n && results.valid && results.ready) begin
			got.max_value = results.max_value;
			got.min_value = results.min_value;
			got.mean_value = results.mean_value;
			got.variance_value = results.variance_value;
			got.item_count = results.item_count;
			book.check_result(got);
		end
	end

	// Watchdog on cycles where no word moves
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samples.valid && samples.ready) || (results.valid && results.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Send one sample word, with an optional idle burst first
	task automatic send_word(input logic signed [SAMPLE_W-1:0] s, input logic fin);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			samples.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		samples.valid <= 1'b1;
		samples.sample <= s;
		samples.last <= fin;
		do
			@(posedge clk);
		while (!samples.ready);
		book.note_sample(s, fin);
		words_sent++;
		if (fin)
			sets_sent++;
	endtask

	function automatic logic signed [SAMPLE_W-1:0] pick_sample(set_flavor_t flavor);
		logic [31:0] r;
		logic signed [31:0] m;
		r = $urandom;
		case (flavor)
			MIX_FULL: begin
				return r;
			end
			MIX_MODERATE: begin
				return $signed(r) >>> $urandom_range(6, 30);
			end
			NEG_ONLY: begin
				m = {1'b0, r[30:0]} >> $urandom_range(0, 24);
				return -m - 1;
			end
			default: begin
				case (r[1:0])
					2'd0: return 32'sh7FFF_FFFF - r[9:2];
					2'd1: return 32'sh8000_0000 + r[9:2];
					2'd2: return 32'sd0;
					default: return $signed(r) >>> 28;
				endcase
			end
		endcase
	endfunction

	// Stimulus
	initial begin
		int len;
		set_flavor_t flavor;
		book = new();
		idle_on = 1'b1;
		words_sent = 0;
		sets_sent = 0;
		arst_n <= 1'b0;
		samples.valid <= 1'b0;
		samples.sample <= '0;
		samples.last <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-word sets at both extremes; negative one leaves max at its floor
		send_word(32'sh7FFF_FFFF, 1'b1);
		send_word(32'sh8000_0000, 1'b1);
		send_word(32'sh0000_0000, 1'b1);
		// extremes in one set: variance saturates, mean rounds down
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sh8000_0000, 1'b1);
		// negative-only set
		send_word(-32'sd98304, 1'b0);
		send_word(-32'sd16384, 1'b0);
		send_word(-32'sd196608, 1'b1);
		// mean of -1 LSB and 0 floors to -1 LSB
		send_word(32'shFFFF_FFFF, 1'b0);
		send_word(32'sh0000_0000, 1'b1);
		// constant set, zero variance
		repeat (3) send_word(32'sh0003_0000, 1'b0);
		send_word(32'sh0003_0000, 1'b1);
		// ordinary mixed set
		send_word(32'sh0064_0000, 1'b0);
		send_word(-32'sh0064_0000, 1'b0);
		send_word(32'sh0032_4000, 1'b1);
		// alternating extremes
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sh7FFF_FFFF, 1'b0);
		send_word(32'sh8000_0000, 1'b0);
		send_word(32'sh7FFF_FFFF, 1'b1);

		// Random sets: mostly short, a few long; no idling in the last stretch
		while (words_sent < ITEM_TARGET) begin
			if (words_sent >= ITEM_TARGET * 85 / 100)
				idle_on = 1'b0;
			else if ($urandom_range(0, 9) == 0)
				idle_on = !idle_on;
			flavor = set_flavor_t'($urandom_range(0, 3));
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
			for (int k = 1; k <= len; k++)
				send_word(pick_sample(flavor), k == len);
		end
		samples.valid <= 1'b0;

		// Drain
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d sample words in %0d sets, %0d set results compared.",
			words_sent, sets_sent, book.sets_checked);
		$display("Sets included extremes, negative-only, constant and saturating ones.");
		if (book.failures == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== running_min_max_mean_variance.f =====
+incdir+sv
sv/rmmv_pkg.sv
sv/rmmv_if.sv
sv/rmmv_div.sv
sv/running_min_max_mean_variance.sv
tb/sv/running_min_max_mean_variance_tb.sv
